### rtl/itd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itd_pkg: shared types and constants of the interval task dispatcher
// Request and response words, opcodes, result kinds, the stored task entry
// and the control groups that pass between the dispatcher's modules.
// ----------------------------------------------------------------------------
package itd_pkg;

	// default number of task table slots
	localparam int DEF_TABLE_DEPTH = 16;

	// request opcodes
	typedef enum logic [2:0] {
		OP_TICK    = 3'd0,
		OP_ADD     = 3'd1,
		OP_ENABLE  = 3'd2,
		OP_DISABLE = 3'd3,
		OP_REMOVE  = 3'd4
	} opcode_t;

	// response kinds
	typedef enum logic [1:0] {
		KIND_DUE   = 2'd0,
		KIND_ADDED = 2'd1,
		KIND_FULL  = 2'd2,
		KIND_DONE  = 2'd3
	} kind_t;

	// one request
	typedef struct packed {
		opcode_t     opcode;
		logic [31:0] now_ms;
		logic [3:0]  slot_index;
		logic [31:0] period_ms;
		logic [7:0]  priority_req;
		logic [7:0]  task_tag;
	} req_t;

	// one response
	typedef struct packed {
		kind_t      kind;
		logic [3:0] slot;
		logic [7:0] tag;
		logic       last;
	} rsp_t;

	// stored task entry (enabled flag is kept apart in flops)
	typedef struct packed {
		logic [31:0] interval;
		logic [31:0] last_run;
		logic [7:0]  prio;
		logic [7:0]  tag;
	} entry_t;

	// entry memory port strobes
	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} ram_ctl_t;

	// operands of the shared compare unit: ge = (a - b) >= c
	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
	} cmp_ops_t;

endpackage

### rtl/itd_entry_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itd_entry_ram: task entry storage
// One write port and one read port with registered read data. Contents are
// undefined until written; only slots below the task count are ever read.
// ----------------------------------------------------------------------------
module itd_entry_ram #(
	parameter int DEPTH  = itd_pkg::DEF_TABLE_DEPTH,
	parameter int ADDR_W = $clog2(itd_pkg::DEF_TABLE_DEPTH)
) (
	input  logic              clk,
	input  itd_pkg::ram_ctl_t ctl,
	input  logic [ADDR_W-1:0] wr_addr,
	input  itd_pkg::entry_t   wr_data,
	input  logic [ADDR_W-1:0] rd_addr,
	output itd_pkg::entry_t   rd_data
);
	import itd_pkg::*;

	entry_t mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### rtl/itd_cmp_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itd_cmp_unit: shared subtract and compare unit
// Computes (a - b) mod 2^32 >= c. Used for the due test of a tick and for
// the priority test of the insertion walk.
// ----------------------------------------------------------------------------
module itd_cmp_unit (
	input  itd_pkg::cmp_ops_t ops,
	output logic              ge
);
	import itd_pkg::*;

	logic [31:0] diff;

	// wrapping difference, then unsigned compare
	assign diff = ops.a - ops.b;
	assign ge   = (diff >= ops.c);

endmodule

### rtl/interval_task_dispatcher_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_task_dispatcher_unit: priority sorted interval task table
// Holds up to TABLE_DEPTH tasks sorted by priority. Ticks report due tasks
// in table order; add, enable, disable and remove edit the table.
//
//   channel | signals                  | direction | payload
//   --------+--------------------------+-----------+-------------------------
//   request | req_valid, req_stall     | in        | req (opcode, time, task)
//   result  | rsp_valid, rsp_stall     | out       | rsp (kind, slot, tag, last)
//
// A request is taken only when the sequencer is idle. A tick visits each task
// in turn; add walks down from the table end, moving each entry of higher
// priority up one slot (a full table answers full without a walk); remove moves
// each entry above the removed slot down one (none when the slot is out of range).
// Entries are handled one at a time: the entry memory has a single read and
// a single write port and the tick and add walks share the compare unit.
// Reset clears the task count and all enabled flags; the entry memory needs no
// clearing. A stalled result holds the sequencer only where it must emit one.
// ----------------------------------------------------------------------------
module interval_task_dispatcher_unit #(
	parameter int TABLE_DEPTH = itd_pkg::DEF_TABLE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  itd_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output itd_pkg::rsp_t rsp
);
	import itd_pkg::*;

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = IDX_W + 1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_TK_CHK,
		ST_ADD_CHK,
		ST_ADD_INS,
		ST_FULL,
		ST_RM_CHK,
		ST_RM_FIN,
		ST_DONE
	} state_t;

	state_t           state_q;
	req_t             req_q;
	logic [IDX_W-1:0] i_q;
	logic [CNT_W-1:0] cnt_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;
	logic [TABLE_DEPTH-1:0] en_q;

	// memory and compare unit hookup
	ram_ctl_t         ram_ctl;
	logic [IDX_W-1:0] wr_addr;
	entry_t           wr_data;
	logic [IDX_W-1:0] rd_addr;
	entry_t           rd_data;
	cmp_ops_t         cmp_ops;
	logic             ge;

	// sequencer decisions
	state_t           state_d;
	logic [IDX_W-1:0] i_d;
	logic [CNT_W-1:0] cnt_d;
	logic             emit_ok;
	logic             emit;
	rsp_t             emit_data;
	logic             en_we;
	logic [IDX_W-1:0] en_addr;
	logic             en_val;

	// index helpers
	logic [CNT_W-1:0]   ix;
	logic [CNT_W-1:0]   ix_p1;
	logic [CNT_W-1:0]   ix_p2;
	logic [IDX_W-1:0]   i_m1;
	logic [IDX_W-1:0]   i_m2;
	logic [CNT_W+3:0]   idx_cmp_a;
	logic [CNT_W+3:0]   idx_cmp_b;
	logic               idx_ok;
	logic [IDX_W+3:0]   idx_wide;
	logic [IDX_W-1:0]   idx;
	logic [CNT_W-1:0]   idx_p1;
	logic [IDX_W+3:0]   slot_wide;
	logic [8:0]         prio_p1;
	logic               due;
	logic               full;

	itd_entry_ram #(
		.DEPTH  (TABLE_DEPTH),
		.ADDR_W (IDX_W)
	) u_ram (
		.clk     (clk),
		.ctl     (ram_ctl),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	itd_cmp_unit u_cmp (
		.ops (cmp_ops),
		.ge  (ge)
	);

	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign emit_ok   = !rsp_valid_q || !rsp_stall;

	// index arithmetic
	assign ix        = {1'b0, i_q};
	assign ix_p1     = ix + CNT_W'(1);
	assign ix_p2     = ix + CNT_W'(2);
	assign i_m1      = i_q - IDX_W'(1);
	assign i_m2      = i_q - IDX_W'(2);
	assign idx_cmp_a = {{CNT_W{1'b0}}, req_q.slot_index};
	assign idx_cmp_b = {4'b0000, cnt_q};
	assign idx_ok    = (idx_cmp_a < idx_cmp_b);
	assign idx_wide  = {{IDX_W{1'b0}}, req_q.slot_index};
	assign idx       = idx_wide[IDX_W-1:0];
	assign idx_p1    = {1'b0, idx} + CNT_W'(1);
	assign slot_wide = {4'b0000, i_q};
	assign prio_p1   = {1'b0, req_q.priority_req} + 9'd1;
	assign full      = (cnt_q == CNT_W'(TABLE_DEPTH));
	assign due       = en_q[i_q] && ge;

	// shared compare operands
	always_comb begin
		if (state_q == ST_ADD_CHK) begin
			cmp_ops.a = {24'd0, rd_data.prio};
			cmp_ops.b = 32'd0;
			cmp_ops.c = {23'd0, prio_p1};
		end else begin
			cmp_ops.a = req_q.now_ms;
			cmp_ops.b = rd_data.last_run;
			cmp_ops.c = rd_data.interval;
		end
	end

	// sequencer next state, memory strobes and result selection
	always_comb begin
		state_d       = state_q;
		i_d           = i_q;
		cnt_d         = cnt_q;
		ram_ctl.wr_en = 1'b0;
		ram_ctl.rd_en = 1'b0;
		wr_addr       = i_q;
		wr_data       = rd_data;
		rd_addr       = i_q;
		en_we         = 1'b0;
		en_addr       = i_q;
		en_val        = 1'b0;
		emit          = 1'b0;
		emit_data     = '{kind: KIND_DONE, slot: 4'd0, tag: 8'd0, last: 1'b1};

		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_d = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				case (req_q.opcode)
					OP_TICK: begin
						if (cnt_q == '0) begin
							state_d = ST_DONE;
						end else begin
							ram_ctl.rd_en = 1'b1;
							rd_addr       = '0;
							i_d           = '0;
							state_d       = ST_TK_CHK;
						end
					end
					OP_ADD: begin
						if (full) begin
							state_d = ST_FULL;
						end else begin
							i_d = cnt_q[IDX_W-1:0];
							if (cnt_q == '0) begin
								state_d = ST_ADD_INS;
							end else begin
								ram_ctl.rd_en = 1'b1;
								rd_addr       = cnt_q[IDX_W-1:0] - IDX_W'(1);
								state_d       = ST_ADD_CHK;
							end
						end
					end
					OP_ENABLE, OP_DISABLE: begin
						en_we   = idx_ok;
						en_addr = idx;
						en_val  = (req_q.opcode == OP_ENABLE);
						state_d = ST_DONE;
					end
					OP_REMOVE: begin
						if (!idx_ok) begin
							state_d = ST_DONE;
						end else begin
							i_d = idx;
							if (idx_p1 < cnt_q) begin
								ram_ctl.rd_en = 1'b1;
								rd_addr       = idx_p1[IDX_W-1:0];
								state_d       = ST_RM_CHK;
							end else begin
								state_d = ST_RM_FIN;
							end
						end
					end
					default: begin
						state_d = ST_DONE;
					end
				endcase
			end
			ST_TK_CHK: begin
				// rd_data holds entry i; hold while a due result cannot go out
				if (!due || emit_ok) begin
					if (due) begin
						ram_ctl.wr_en    = 1'b1;
						wr_addr          = i_q;
						wr_data          = rd_data;
						wr_data.last_run = req_q.now_ms;
						emit             = 1'b1;
						emit_data        = '{kind: KIND_DUE, slot: slot_wide[3:0],
							tag: rd_data.tag, last: 1'b0};
					end
					if (ix_p1 < cnt_q) begin
						ram_ctl.rd_en = 1'b1;
						rd_addr       = ix_p1[IDX_W-1:0];
						i_d           = ix_p1[IDX_W-1:0];
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_ADD_CHK: begin
				// rd_data holds entry i-1; move it up while its priority is higher
				if (ge) begin
					ram_ctl.wr_en = 1'b1;
					wr_addr       = i_q;
					wr_data       = rd_data;
					en_we         = 1'b1;
					en_addr       = i_q;
					en_val        = en_q[i_m1];
					i_d           = i_m1;
					if (ix > CNT_W'(1)) begin
						ram_ctl.rd_en = 1'b1;
						rd_addr       = i_m2;
					end else begin
						state_d = ST_ADD_INS;
					end
				end else begin
					state_d = ST_ADD_INS;
				end
			end
			ST_ADD_INS: begin
				if (emit_ok) begin
					ram_ctl.wr_en = 1'b1;
					wr_addr       = i_q;
					wr_data       = '{interval: req_q.period_ms, last_run: 32'd0,
						prio: req_q.priority_req, tag: req_q.task_tag};
					en_we         = 1'b1;
					en_addr       = i_q;
					en_val        = 1'b1;
					cnt_d         = cnt_q + CNT_W'(1);
					emit          = 1'b1;
					emit_data     = '{kind: KIND_ADDED, slot: slot_wide[3:0],
						tag: req_q.task_tag, last: 1'b1};
					state_d       = ST_IDLE;
				end
			end
			ST_FULL: begin
				if (emit_ok) begin
					emit      = 1'b1;
					emit_data = '{kind: KIND_FULL, slot: 4'd0, tag: 8'd0, last: 1'b1};
					state_d   = ST_IDLE;
				end
			end
			ST_RM_CHK: begin
				// rd_data holds entry i+1; move it down one slot
				ram_ctl.wr_en = 1'b1;
				wr_addr       = i_q;
				wr_data       = rd_data;
				en_we         = 1'b1;
				en_addr       = i_q;
				en_val        = en_q[ix_p1[IDX_W-1:0]];
				i_d           = ix_p1[IDX_W-1:0];
				if (ix_p2 < cnt_q) begin
					ram_ctl.rd_en = 1'b1;
					rd_addr       = ix_p2[IDX_W-1:0];
				end else begin
					state_d = ST_RM_FIN;
				end
			end
			ST_RM_FIN: begin
				cnt_d   = cnt_q - CNT_W'(1);
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (emit_ok) begin
					emit    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// sequencer state, request capture and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			req_q       <= '0;
			i_q         <= '0;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			state_q <= state_d;
			i_q     <= i_d;
			cnt_q   <= cnt_d;
			if (state_q == ST_IDLE && req_valid) begin
				req_q <= req;
			end
			if (emit) begin
				rsp_valid_q <= 1'b1;
				rsp_q       <= emit_data;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// enabled flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q <= '0;
		end else if (en_we) begin
			en_q[en_addr] <= en_val;
		end
	end

	// task count stays within the table
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(TABLE_DEPTH))
		else $error("task count beyond table depth");

	// a done result closes the request and frees the sequencer
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && emit_ok) |=>
		(state_q == ST_IDLE && rsp_valid && rsp.last && rsp.kind == KIND_DONE))
		else $error("done result not delivered as last");

	// a completed insert grows the table by one
	a_add_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ADD_INS && emit_ok) |=> (cnt_q == $past(cnt_q) + CNT_W'(1)))
		else $error("insert did not grow task count");

	// a remove shrinks the table by one
	a_rm_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RM_FIN) |=> (cnt_q == $past(cnt_q) - CNT_W'(1)))
		else $error("remove did not shrink task count");

	// a due report is never the final result of a tick
	a_due_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.kind == KIND_DUE) |-> !rsp.last)
		else $error("due report marked last");

endmodule

### tb/sv/interval_task_dispatcher_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_task_dispatcher_unit_tb: self-checking bench for the task dispatcher
// Drives a short table of directed requests and then a long run of random
// ones, with random gaps on the request side and random stalls on the result side. A model of the
// priority-sorted task table predicts every result, and each accepted result
// is checked field by field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module interval_task_dispatcher_unit_tb;
	import itd_pkg::*;

	localparam int unsigned DEPTH       = DEF_TABLE_DEPTH;
	localparam int unsigned RAND_ITEMS  = 475;
	localparam int unsigned HOLD_AT     = 120;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned PAUSE_AT    = 260;
	localparam int unsigned CALM_ITEMS  = 70;
	localparam int unsigned TAIL_CYCLES = 64;
	localparam int unsigned CYCLE_LIMIT = 400000;

	// opcodes the block does not define: they must only report done
	localparam logic [2:0] OP_SPARE_LO = 3'd5;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;

	typedef struct {
		req_t        r;
		int unsigned reps;
		bit          typed;
		rsp_t        want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	// task table model
	logic [31:0] tbl_interval [DEPTH];
	logic [31:0] tbl_last_run [DEPTH];
	logic [7:0]  tbl_prio     [DEPTH];
	logic        tbl_enabled  [DEPTH];
	logic [7:0]  tbl_tag      [DEPTH];
	int unsigned tbl_count;
	int unsigned tbl_peak;

	rsp_t     step_results [$];
	rsp_t     rsp_awaited  [$];
	dir_row_t dir_rows     [$];

	bit          calm;
	bit          hold_off_req;
	bit          hold_off_done;
	int unsigned err_count;
	int unsigned cycle_count;
	int unsigned items_sent;
	int unsigned cnt_due, cnt_added, cnt_full, cnt_done;

	interval_task_dispatcher_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic req_t mk_req(input logic [2:0] op, input logic [31:0] now,
			input logic [3:0] slot, input logic [31:0] ivl, input logic [7:0] prio,
			input logic [7:0] tag);
		req_t r;
		r.opcode       = opcode_t'(op);
		r.now_ms       = now;
		r.slot_index   = slot;
		r.period_ms    = ivl;
		r.priority_req = prio;
		r.task_tag     = tag;
		return r;
	endfunction

	function automatic rsp_t mk_rsp(input kind_t k, input logic [3:0] slot,
			input logic [7:0] tag, input logic last);
		rsp_t s;
		s.kind = k;
		s.slot = slot;
		s.tag  = tag;
		s.last = last;
		return s;
	endfunction

	function automatic void add_row(input req_t r, input int unsigned reps,
			input bit typed, input rsp_t want);
		dir_row_t row;
		row.r     = r;
		row.reps  = reps;
		row.typed = typed;
		row.want  = want;
		dir_rows.push_back(row);
	endfunction

	function automatic void copy_slot(input int unsigned dst, input int unsigned src);
		tbl_interval[dst] = tbl_interval[src];
		tbl_last_run[dst] = tbl_last_run[src];
		tbl_prio[dst]     = tbl_prio[src];
		tbl_enabled[dst]  = tbl_enabled[src];
		tbl_tag[dst]      = tbl_tag[src];
	endfunction

	// apply one request to the table model; its results land in step_results
	function automatic void predict_request(input req_t r);
		int unsigned i;
		int unsigned pos;
		logic [31:0] elapsed;
		step_results.delete();
		case (r.opcode)
			OP_TICK: begin
				for (i = 0; i < tbl_count; i++) begin
					elapsed = r.now_ms - tbl_last_run[i];
					if (tbl_enabled[i] && (tbl_interval[i] == '0 || elapsed >= tbl_interval[i])) begin
						tbl_last_run[i] = r.now_ms;
						step_results.push_back(mk_rsp(KIND_DUE, i[3:0], tbl_tag[i], 1'b0));
					end
				end
			end
			OP_ADD: begin
				if (tbl_count >= DEPTH) begin
					step_results.push_back(mk_rsp(KIND_FULL, 4'd0, 8'd0, 1'b1));
				end else begin
					// stable insert: after every entry of equal or lower value
					pos = tbl_count;
					while (pos > 0 && tbl_prio[pos - 1] > r.priority_req) begin
						copy_slot(pos, pos - 1);
						pos--;
					end
					tbl_interval[pos] = r.period_ms;
					tbl_last_run[pos] = '0;
					tbl_prio[pos]     = r.priority_req;
					tbl_enabled[pos]  = 1'b1;
					tbl_tag[pos]      = r.task_tag;
					tbl_count++;
					if (tbl_count > tbl_peak)
						tbl_peak = tbl_count;
					step_results.push_back(mk_rsp(KIND_ADDED, pos[3:0], r.task_tag, 1'b1));
				end
			end
			OP_ENABLE: begin
				if (r.slot_index < tbl_count)
					tbl_enabled[r.slot_index] = 1'b1;
			end
			OP_DISABLE: begin
				if (r.slot_index < tbl_count)
					tbl_enabled[r.slot_index] = 1'b0;
			end
			OP_REMOVE: begin
				if (r.slot_index < tbl_count) begin
					for (i = r.slot_index; i + 1 < tbl_count; i++)
						copy_slot(i, i + 1);
					tbl_count--;
				end
			end
			default: ;
		endcase
		if (r.opcode != OP_ADD)
			step_results.push_back(mk_rsp(KIND_DONE, 4'd0, 8'd0, 1'b1));
	endfunction

	// offer one request until taken, then record what it should produce
	task automatic issue(input req_t r, input bit typed, input rsp_t want);
		req       <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		predict_request(r);
		if (typed)
			rsp_awaited.push_back(want);
		else
			foreach (step_results[k])
				rsp_awaited.push_back(step_results[k]);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic idle_gap();
		if (!calm && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
	endtask

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("interval_task_dispatcher_unit verification failed");
			$finish;
		end
	end

	// result checker
	always @(posedge clk) begin : result_check
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (rsp_awaited.size() == 0) begin
				$error("result with none awaited: kind %0d slot %0d tag %0d last %0d",
					rsp.kind, rsp.slot, rsp.tag, rsp.last);
				err_count++;
			end else begin
				want = rsp_awaited.pop_front();
				if (rsp.kind !== want.kind) begin
					$error("kind: expected %0d, got %0d", want.kind, rsp.kind);
					err_count++;
				end
				if (rsp.slot !== want.slot) begin
					$error("slot: expected %0d, got %0d", want.slot, rsp.slot);
					err_count++;
				end
				if (rsp.tag !== want.tag) begin
					$error("tag: expected %0d, got %0d", want.tag, rsp.tag);
					err_count++;
				end
				if (rsp.last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, rsp.last);
					err_count++;
				end
				case (want.kind)
					KIND_DUE:   cnt_due++;
					KIND_ADDED: cnt_added++;
					KIND_FULL:  cnt_full++;
					default:    cnt_done++;
				endcase
			end
		end
	end

	// result side: short random stalls, one long hold-off, none at the end
	initial begin : result_side
		int unsigned burst;
		burst     = 0;
		rsp_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_req && !hold_off_done) begin
				hold_off_done = 1'b1;
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				rsp_stall <= 1'b0;
			end else if (calm) begin
				rsp_stall <= 1'b0;
			end else if (burst > 0) begin
				rsp_stall <= 1'b1;
				burst--;
			end else if ($urandom_range(0, 4) == 0) begin
				rsp_stall <= 1'b1;
				burst = $urandom_range(0, 3);
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	// request side
	initial begin : request_side
		req_t        r;
		int unsigned k;
		int unsigned n;
		int unsigned pick;
		logic [2:0]  spare;
		logic [31:0] clock_ms;
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		clock_ms  = '0;

		// directed rows; typed results are the obvious ones
		add_row(mk_req(OP_TICK, 32'd0, 4'd0, '0, 8'd0, 8'd0), 1, 1'b1,
			mk_rsp(KIND_DONE, 4'd0, 8'd0, 1'b1));
		add_row(mk_req(OP_ADD, '0, 4'd0, 32'd0, 8'h80, 8'hA5), 1, 1'b1,
			mk_rsp(KIND_ADDED, 4'd0, 8'hA5, 1'b1));
		add_row(mk_req(OP_ADD, '0, 4'd0, 32'hFFFF_FFFF, 8'h00, 8'h00), 1, 1'b0, '0);
		add_row(mk_req(OP_ADD, '0, 4'd0, 32'd10, 8'hFF, 8'hFF), 1, 1'b0, '0);
		// equal priority goes behind the earlier task
		add_row(mk_req(OP_ADD, '0, 4'd0, 32'd100, 8'h80, 8'h5A), 1, 1'b0, '0);
		add_row(mk_req(OP_TICK, 32'd0, 4'd0, '0, 8'd0, 8'd0), 1, 1'b0, '0);
		add_row(mk_req(OP_TICK, 32'hFFFF_FFFF, 4'd0, '0, 8'd0, 8'd0), 1, 1'b0, '0);
		// time wraps past zero
		add_row(mk_req(OP_TICK, 32'd5, 4'd0, '0, 8'd0, 8'd0), 1, 1'b0, '0);
		add_row(mk_req(OP_DISABLE, '0, 4'd0, '0, 8'd0, 8'd0), 1, 1'b0, '0);
		add_row(mk_req(OP_TICK, 32'd1000, 4'd0, '0, 8'd0, 8'd0), 1, 1'b0, '0);
		add_row(mk_req(OP_ENABLE, '0, 4'd0, '0, 8'd0, 8'd0), 1, 1'b0, '0);
		// slot indexes at or past the task count are ignored
		add_row(mk_req(OP_ENABLE, '0, 4'd15, '0, 8'd0, 8'd0), 1, 1'b1,
			mk_rsp(KIND_DONE, 4'd0, 8'd0, 1'b1));
		add_row(mk_req(OP_DISABLE, '0, 4'd4, '0, 8'd0, 8'd0), 1, 1'b1,
			mk_rsp(KIND_DONE, 4'd0, 8'd0, 1'b1));
		add_row(mk_req(OP_REMOVE, '0, 4'd1, '0, 8'd0, 8'd0), 1, 1'b0, '0);
		add_row(mk_req(OP_REMOVE, '0, 4'd15, '0, 8'd0, 8'd0), 1, 1'b1,
			mk_rsp(KIND_DONE, 4'd0, 8'd0, 1'b1));
		add_row(mk_req(OP_SPARE_LO, 32'hFFFF_FFFF, 4'd15, '1, 8'hFF, 8'hFF), 1, 1'b1,
			mk_rsp(KIND_DONE, 4'd0, 8'd0, 1'b1));
		add_row(mk_req(OP_SPARE_HI, '0, 4'd0, '0, 8'd0, 8'd0), 1, 1'b1,
			mk_rsp(KIND_DONE, 4'd0, 8'd0, 1'b1));
		// fill the table, tags counting up, then try one more
		add_row(mk_req(OP_ADD, '0, 4'd0, 32'd0, 8'h40, 8'h30), 13, 1'b0, '0);
		add_row(mk_req(OP_ADD, '0, 4'd0, 32'd7, 8'h01, 8'h77), 1, 1'b1,
			mk_rsp(KIND_FULL, 4'd0, 8'd0, 1'b1));
		// every task due at once
		add_row(mk_req(OP_TICK, 32'hFFFF_FFFE, 4'd0, '0, 8'd0, 8'd0), 1, 1'b0, '0);
		add_row(mk_req(OP_REMOVE, '0, 4'd15, '0, 8'd0, 8'd0), 1, 1'b0, '0);
		add_row(mk_req(OP_REMOVE, '0, 4'd0, '0, 8'd0, 8'd0), 1, 1'b0, '0);

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[i]) begin
			for (k = 0; k < dir_rows[i].reps; k++) begin
				r = dir_rows[i].r;
				r.task_tag = r.task_tag + k[7:0];
				issue(r, dir_rows[i].typed, dir_rows[i].want);
				idle_gap();
			end
		end

		for (n = 0; n < RAND_ITEMS; n++) begin
			if (n == HOLD_AT)
				hold_off_req = 1'b1;
			if (n == PAUSE_AT) begin
				req_valid <= 1'b0;
				while (rsp_awaited.size() != 0) @(posedge clk);
				@(negedge clk);
			end
			if (n == RAND_ITEMS - CALM_ITEMS)
				calm = 1'b1;

			// random content everywhere, then shape the fields that matter
			r              = '0;
			r.now_ms       = $urandom();
			r.slot_index   = 4'($urandom_range(0, 15));
			r.period_ms    = $urandom();
			r.priority_req = 8'($urandom_range(0, 255));
			r.task_tag     = 8'($urandom_range(0, 255));
			pick           = $urandom_range(0, 99);
			if (pick < 35) begin
				r.opcode = OP_TICK;
				if ($urandom_range(0, 19) == 0)
					clock_ms = $urandom();
				else
					clock_ms = clock_ms + $urandom_range(0, 40);
				r.now_ms = clock_ms;
			end else if (pick < 60) begin
				r.opcode = OP_ADD;
				case ($urandom_range(0, 9))
					0, 1:    r.period_ms = '0;
					8:       ;
					9:       r.period_ms = '1;
					default: r.period_ms = $urandom_range(1, 80);
				endcase
				// narrow priorities give plenty of ties
				if ($urandom_range(0, 1) == 0)
					r.priority_req = 8'($urandom_range(0, 7));
			end else if (pick < 97) begin
				if (pick < 70)
					r.opcode = OP_ENABLE;
				else if (pick < 80)
					r.opcode = OP_DISABLE;
				else
					r.opcode = OP_REMOVE;
				if (tbl_count > 0 && $urandom_range(0, 6) != 0)
					r.slot_index = 4'($urandom_range(0, tbl_count - 1));
			end else begin
				spare    = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
				r.opcode = opcode_t'(spare);
			end
			issue(r, 1'b0, '0);
			idle_gap();
		end
		req_valid <= 1'b0;

		while (rsp_awaited.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Ran %0d requests through the task table (peak %0d of %0d tasks).",
			items_sent, tbl_peak, DEPTH);
		$display("Results checked: %0d due, %0d added, %0d table full, %0d done.",
			cnt_due, cnt_added, cnt_full, cnt_done);
		if (err_count == 0)
			$display("interval_task_dispatcher_unit verification clean");
		else
			$display("interval_task_dispatcher_unit verification failed");
		$finish;
	end

endmodule
